// ===== rtl/rope_pkg.sv =====
// Shared constants, codes and types of the rotary embedding pair rotator.
package rope_pkg;

    // Default table geometry: token positions and elements per head vector.
    localparam int unsigned MAX_POS_DEF  = 512;
    localparam int unsigned MAX_DIMS_DEF = 128;

    // Reset value of the rotated pair count.
    localparam logic [6:0] HALF_DIMS_RESET = 7'd64;

    // Register index as seen in bit 2 of the byte address.
    localparam logic REG_HALF_DIMS = 1'b0;

    // Item kinds carried on the input tuser.
    typedef enum logic {
        MODE_WRITE  = 1'b0,
        MODE_ROTATE = 1'b1
    } rope_mode_t;

    // Decode flags from the address stage.
    typedef struct packed {
        logic wr_ok;   // write lies inside the table
        logic err;     // rotate cannot be served
    } rope_dec_t;

endpackage

// ===== rtl/rotary_embedding_pair_rotate_top.sv =====
// Top level of the rotary position embedding pair rotator.
// A rotate request passes stage one and the datapath stages before its result shows on m_tvalid.
// Throughput: one request per cycle unless results stall, set by each RAM's single read port.
// A write request inside the table updates it at its accept edge; writes return no result.
// Reset clears all valid bits and sets half_dims to 64; the table is not cleared.
module rotary_embedding_pair_rotate_top #(
    parameter int unsigned MAX_POS  = rope_pkg::MAX_POS_DEF,
    parameter int unsigned MAX_DIMS = rope_pkg::MAX_DIMS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // position, elem_index, x_value, y_value, table_cos, table_sin
    input  logic [0:0]  s_tuser,  // mode
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // out_low, out_high
    output logic [0:0]  m_tuser,  // index_error
    // Register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned DEPTH = MAX_POS * MAX_DIMS;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [6:0]          half_dims_reg;
    logic                cfg_wr;
    logic                accept;
    logic                is_write;
    logic [AW-1:0]       lo_addr;
    logic [AW-1:0]       hi_addr;
    rope_pkg::rope_dec_t dec;
    logic [31:0]         wr_word;
    logic                tbl_wr;
    logic [31:0]         lo_word;
    logic [31:0]         hi_word;
    logic                v1_reg;
    logic                rdy1;
    logic [15:0]         x1_reg;
    logic [15:0]         y1_reg;
    logic                err1_reg;
    logic                dp_ready;
    logic [15:0]         out_low;
    logic [15:0]         out_high;
    logic                out_error;

    // Register port: always ready, one writable register.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == rope_pkg::REG_HALF_DIMS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            half_dims_reg <= rope_pkg::HALF_DIMS_RESET;
        end else if (cfg_wr) begin
            half_dims_reg <= pwdata[6:0];
        end
    end

    always_comb begin
        if (paddr[2] == rope_pkg::REG_HALF_DIMS) begin
            prdata = {25'd0, half_dims_reg};
        end else begin
            prdata = 32'd0;
        end
    end

    // Address generation and range checks.
    rope_addr #(
        .MAX_POS  (MAX_POS),
        .MAX_DIMS (MAX_DIMS)
    ) u_addr (
        .position   (s_tdata[8:0]),
        .elem_index (s_tdata[15:9]),
        .half_dims  (half_dims_reg),
        .lo_addr    (lo_addr),
        .hi_addr    (hi_addr),
        .dec        (dec)
    );

    // Request handshake; the table is written and read at the accept edge.
    assign rdy1     = !v1_reg || dp_ready;
    assign s_tready = rdy1;
    assign accept   = s_tvalid && s_tready;
    assign is_write = (s_tuser[0] == rope_pkg::MODE_WRITE);
    assign tbl_wr   = accept && is_write && dec.wr_ok;
    assign wr_word  = {s_tdata[63:48], s_tdata[79:64]};

    // Two copies of the table so both elements of a pair are read in the same cycle.
    rope_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram_lo (
        .aclk    (aclk),
        .wr_en   (tbl_wr),
        .wr_addr (lo_addr),
        .wr_data (wr_word),
        .rd_en   (accept),
        .rd_addr (lo_addr),
        .rd_data (lo_word)
    );

    rope_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_ram_hi (
        .aclk    (aclk),
        .wr_en   (tbl_wr),
        .wr_addr (lo_addr),
        .wr_data (wr_word),
        .rd_en   (accept),
        .rd_addr (hi_addr),
        .rd_data (hi_word)
    );

    // Stage one: operands wait beside the table read data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (rdy1) begin
            v1_reg <= accept && !is_write;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            x1_reg   <= s_tdata[31:16];
            y1_reg   <= s_tdata[47:32];
            err1_reg <= dec.err;
        end
    end

    // Arithmetic stages and the output register.
    rope_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (v1_reg),
        .in_ready    (dp_ready),
        .x_value     (x1_reg),
        .y_value     (y1_reg),
        .index_error (err1_reg),
        .lo_word     (lo_word),
        .hi_word     (hi_word),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_low     (out_low),
        .out_high    (out_high),
        .out_error   (out_error)
    );

    assign m_tdata = {out_high, out_low};
    assign m_tuser = out_error;

endmodule

// ===== rtl/rope_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module rope_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = rope_pkg::MAX_POS_DEF * rope_pkg::MAX_DIMS_DEF,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port; read data holds while rd_en is low.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/rope_addr.sv =====
// Table address generation and range checks for write and rotate requests.
module rope_addr #(
    parameter int unsigned MAX_POS  = rope_pkg::MAX_POS_DEF,
    parameter int unsigned MAX_DIMS = rope_pkg::MAX_DIMS_DEF,
    localparam int unsigned AW      = $clog2(MAX_POS * MAX_DIMS)
) (
    input  logic [8:0]          position,
    input  logic [6:0]          elem_index,
    input  logic [6:0]          half_dims,
    output logic [AW-1:0]       lo_addr,
    output logic [AW-1:0]       hi_addr,
    output rope_pkg::rope_dec_t dec
);

    logic [31:0] row;
    logic [31:0] lo_full;
    logic [31:0] hi_full;
    logic [7:0]  idx_plus_half;

    // Row base is a multiply by a constant; the pair partner sits half_dims further on.
    always_comb begin
        row           = 32'(position) * 32'(MAX_DIMS);
        idx_plus_half = {1'b0, elem_index} + {1'b0, half_dims};
        lo_full       = row + 32'(elem_index);
        hi_full       = row + 32'(idx_plus_half);
        lo_addr       = lo_full[AW-1:0];
        hi_addr       = hi_full[AW-1:0];
    end

    // Range checks for both kinds of request.
    always_comb begin
        dec.err   = (elem_index >= half_dims) ||
                    (32'(idx_plus_half) >= MAX_DIMS) ||
                    (32'(position) >= MAX_POS);
        dec.wr_ok = (32'(position) < MAX_POS) && (32'(elem_index) < MAX_DIMS);
    end

endmodule

// ===== rtl/rope_datapath.sv =====
// Multiply, sum and round-saturate pipeline for one rotated element pair.
module rope_datapath (
    input  logic        aclk,
    input  logic        aresetn,
    // From the table read stage
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] x_value,
    input  logic [15:0] y_value,
    input  logic        index_error,
    input  logic [31:0] lo_word,
    input  logic [31:0] hi_word,
    // Result side
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] out_low,
    output logic [15:0] out_high,
    output logic        out_error
);

    // Q10.22 to Q8.8: round to nearest with ties upward, then clamp.
    function automatic logic [15:0] round_sat(input logic signed [32:0] sum);
        logic signed [33:0] biased;
        logic signed [19:0] q;
        begin
            biased = {sum[32], sum} + 34'sd8192;
            q      = biased[33:14];
            if (q > 20'sd32767) begin
                round_sat = 16'h7FFF;
            end else if (q < -20'sd32768) begin
                round_sat = 16'h8000;
            end else begin
                round_sat = q[15:0];
            end
        end
    endfunction

    logic               v2_reg, v3_reg, v4_reg;
    logic               rdy2, rdy3, rdy4;
    logic signed [31:0] p_xc0_reg, p_ys0_reg, p_yc1_reg, p_xs1_reg;
    logic               err2_reg, err3_reg, err4_reg;
    logic signed [32:0] sum_lo_reg, sum_hi_reg;
    logic [15:0]        low4_reg, high4_reg;

    // Each stage moves when it is empty or its successor takes its contents.
    always_comb begin
        rdy4     = !v4_reg || out_ready;
        rdy3     = !v3_reg || rdy4;
        rdy2     = !v2_reg || rdy3;
        in_ready = rdy2;
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (rdy2) begin
                v2_reg <= in_valid;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
            if (rdy4) begin
                v4_reg <= v3_reg;
            end
        end
    end

    // Stage two: four signed 16 by 16 products.
    always_ff @(posedge aclk) begin
        if (rdy2 && in_valid) begin
            p_xc0_reg <= $signed(x_value) * $signed(lo_word[31:16]);
            p_ys0_reg <= $signed(y_value) * $signed(lo_word[15:0]);
            p_yc1_reg <= $signed(y_value) * $signed(hi_word[31:16]);
            p_xs1_reg <= $signed(x_value) * $signed(hi_word[15:0]);
            err2_reg  <= index_error;
        end
    end

    // Stage three: the two rotation sums.
    always_ff @(posedge aclk) begin
        if (rdy3 && v2_reg) begin
            sum_lo_reg <= 33'(p_xc0_reg) - 33'(p_ys0_reg);
            sum_hi_reg <= 33'(p_yc1_reg) + 33'(p_xs1_reg);
            err3_reg   <= err2_reg;
        end
    end

    // Stage four: rounding, saturation and forcing zeros on an index error.
    always_ff @(posedge aclk) begin
        if (rdy4 && v3_reg) begin
            low4_reg  <= err3_reg ? 16'h0000 : round_sat(sum_lo_reg);
            high4_reg <= err3_reg ? 16'h0000 : round_sat(sum_hi_reg);
            err4_reg  <= err3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_low   = low4_reg;
    assign out_high  = high4_reg;
    assign out_error = err4_reg;

endmodule

// ===== rtl/rope_checker.sv =====
// Port-level checks for the rotary embedding pair rotator, bound to the top level.
module rope_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser,
    input logic        psel,
    input logic        penable,
    input logic        pwrite,
    input logic        pready,
    input logic [2:0]  paddr,
    input logic [31:0] pwdata,
    input logic [31:0] prdata
);

    // A result held back by the sink keeps its contents.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // A result flagged with an index error carries zero elements.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tdata == 32'd0)
        else $error("index error result not zero");

    // No result is offered in the cycle after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A register write is read back on the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        psel && penable && pwrite && pready && (paddr[2] == rope_pkg::REG_HALF_DIMS) |=>
            (paddr[2] != rope_pkg::REG_HALF_DIMS) ||
            (prdata == {25'd0, $past(pwdata[6:0])}))
        else $error("half_dims read back mismatch");

endmodule

bind rotary_embedding_pair_rotate_top rope_checker u_rope_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
);
